// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the RTL of the font file stream parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clock, resetn, ante, cons, msg) \
    label: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ffsp_pkg.sv =====
// Types, codes and constants of the font file stream parser.
package ffsp_pkg;

    localparam int unsigned MAX_DIM_DEFAULT = 4096;

    typedef enum logic {
        CMD_BYTE = 1'b0,
        CMD_END  = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        KIND_CHAR_HDR = 2'd0,
        KIND_PIXEL    = 2'd1,
        KIND_DONE     = 2'd2,
        KIND_ERROR    = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ERR_SIGNATURE = 3'd0,
        ERR_VERSION   = 3'd1,
        ERR_NO_CHARS  = 3'd2,
        ERR_TOO_BIG   = 3'd3,
        ERR_TRUNCATED = 3'd4
    } err_t;

    typedef struct packed {
        cmd_t       command;
        logic [7:0] data_byte;
    } item_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] char_index;
        logic [12:0] width;
        logic [12:0] height;
        logic [23:0] pixel_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        err_t        error_code;
    } result_t;

    localparam logic [15:0] VERSION_ALPHA = 16'd1;
    localparam logic [15:0] VERSION_RGBA  = 16'd2;
    localparam logic [7:0]  FONT_HDR_LAST = 8'd255;
    localparam logic [7:0]  CHAR_HDR_LAST = 8'd31;
    localparam logic [7:0]  WHITE         = 8'hFF;

    // Signature bytes ".rfn" by position.
    function automatic logic [7:0] rfn_mark(input logic [1:0] idx);
        logic [7:0] val;
        case (idx)
            2'd0:    val = 8'h2E;
            2'd1:    val = 8'h72;
            2'd2:    val = 8'h66;
            default: val = 8'h6E;
        endcase
        return val;
    endfunction

endpackage

// ===== rtl/core/font_file_stream_parser.sv =====
// Streaming parser for bitmap font files, with its output buffer and checks.
//
// The parser takes one file byte, or the end command, per item and can accept an
// item in every clock cycle. Each item is decoded combinationally: one small
// state update plus, at the last byte of a character header, one 13 by 13 bit
// multiply that sets the pixel count of that character. An item causes at most one
// result item, which is written into a two-entry output buffer (output register
// plus skid register). Upstream is stalled only while that skid register is full,
// so the block keeps taking items while one result waits downstream, and with no
// downstream stall it sustains one item per cycle, each result being registered in
// the output register. The font header (256 bytes) is checked after its
// last byte: signature, then version, then character count. Each 32-byte character
// header gives width and height, each limited to MAX_DIM. Version 1 pixels are a
// single alpha byte shown as white; version 2 pixels are R, G, B, A. After an error
// all bytes are ignored until the end command, and any end command returns the
// parser to its reset state. The font complete item is given by the end command
// that follows the last character: its last pixel, or its header if it has none.
module font_file_stream_parser #(
    parameter int unsigned MAX_DIM = ffsp_pkg::MAX_DIM_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  ffsp_pkg::item_t   item,
    output logic              result_valid,
    input  logic              result_stall,
    output ffsp_pkg::result_t result
);
    import ffsp_pkg::*;

    `include "assert_macros.svh"

    localparam logic [15:0] MAX_DIM_W = 16'(MAX_DIM);

    typedef enum logic [2:0] {
        PH_FONT_HDR,
        PH_CHAR_HDR,
        PH_PIXELS,
        PH_DONE,
        PH_ERROR
    } phase_t;

    phase_t      phase_reg, phase_next;
    logic [7:0]  hdr_cnt_reg, hdr_cnt_next;
    logic        sig_ok_reg, sig_ok_next;
    logic        rgba_reg, rgba_next;
    logic [15:0] char_total_reg, char_total_next;
    logic [15:0] cur_char_reg, cur_char_next;
    logic [12:0] cur_width_reg, cur_width_next;
    logic [12:0] cur_height_reg, cur_height_next;
    logic [24:0] pixels_left_reg, pixels_left_next;
    logic [23:0] pixel_pos_reg, pixel_pos_next;
    logic [1:0]  byte_in_pixel_reg, byte_in_pixel_next;
    logic [23:0] hold_reg, hold_next;

    logic        out_valid_reg, out_valid_next;
    result_t     out_reg, out_next;
    logic        skid_valid_reg, skid_valid_next;
    result_t     skid_reg, skid_next;

    logic        accept;
    logic        res_valid;
    result_t     res;
    logic [15:0] dim_word;
    logic [15:0] next_char_idx;
    logic [24:0] left_dec;
    logic [25:0] area;
    logic        out_pop;

    assign accept        = item_valid && !item_stall;
    assign item_stall    = skid_valid_reg;
    assign result_valid  = out_valid_reg;
    assign result        = out_reg;
    assign next_char_idx = cur_char_reg + 16'd1;
    assign left_dec      = pixels_left_reg - 25'd1;
    assign area          = cur_width_reg * cur_height_reg;
    assign out_pop       = out_valid_reg && !result_stall;

    // Parser state update and result for the accepted item.
    always_comb
    begin
        phase_next         = phase_reg;
        hdr_cnt_next       = hdr_cnt_reg;
        sig_ok_next        = sig_ok_reg;
        rgba_next          = rgba_reg;
        char_total_next    = char_total_reg;
        cur_char_next      = cur_char_reg;
        cur_width_next     = cur_width_reg;
        cur_height_next    = cur_height_reg;
        pixels_left_next   = pixels_left_reg;
        pixel_pos_next     = pixel_pos_reg;
        byte_in_pixel_next = byte_in_pixel_reg;
        hold_next          = hold_reg;
        res_valid          = 1'b0;
        res                = '0;
        dim_word           = '0;

        if (accept) begin
            if (item.command == CMD_END) begin
                if (phase_reg == PH_DONE) begin
                    res_valid = 1'b1;
                    res.kind  = KIND_DONE;
                end else if (phase_reg != PH_ERROR) begin
                    res_valid       = 1'b1;
                    res.kind        = KIND_ERROR;
                    res.char_index  = cur_char_reg;
                    res.error_code  = ERR_TRUNCATED;
                end
                phase_next         = PH_FONT_HDR;
                hdr_cnt_next       = '0;
                sig_ok_next        = 1'b1;
                rgba_next          = 1'b0;
                char_total_next    = '0;
                cur_char_next      = '0;
                cur_width_next     = '0;
                cur_height_next    = '0;
                pixels_left_next   = '0;
                pixel_pos_next     = '0;
                byte_in_pixel_next = '0;
                hold_next          = '0;
            end else begin
                unique case (phase_reg)
                    PH_FONT_HDR:
                    begin
                        if (hdr_cnt_reg < 8'd4) begin
                            if (item.data_byte != rfn_mark(hdr_cnt_reg[1:0])) begin
                                sig_ok_next = 1'b0;
                            end
                        end else if (hdr_cnt_reg == 8'd4) begin
                            hold_next = {16'd0, item.data_byte};
                        end else if (hdr_cnt_reg == 8'd5) begin
                            hold_next = {8'd0, item.data_byte, hold_reg[7:0]};
                        end else if (hdr_cnt_reg == 8'd6) begin
                            char_total_next = {8'd0, item.data_byte};
                        end else if (hdr_cnt_reg == 8'd7) begin
                            char_total_next = {item.data_byte, char_total_reg[7:0]};
                        end

                        if (hdr_cnt_reg == FONT_HDR_LAST) begin
                            hdr_cnt_next = '0;
                            hold_next    = '0;
                            if (!sig_ok_reg) begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.char_index = cur_char_reg;
                                res.error_code = ERR_SIGNATURE;
                                phase_next     = PH_ERROR;
                            end else if (hold_reg[15:0] != VERSION_ALPHA &&
                                         hold_reg[15:0] != VERSION_RGBA) begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.char_index = cur_char_reg;
                                res.error_code = ERR_VERSION;
                                phase_next     = PH_ERROR;
                            end else if (char_total_reg == 16'd0) begin
                                res_valid      = 1'b1;
                                res.kind       = KIND_ERROR;
                                res.char_index = cur_char_reg;
                                res.error_code = ERR_NO_CHARS;
                                phase_next     = PH_ERROR;
                            end else begin
                                rgba_next     = (hold_reg[15:0] == VERSION_RGBA);
                                cur_char_next = '0;
                                phase_next    = PH_CHAR_HDR;
                            end
                        end else begin
                            hdr_cnt_next = hdr_cnt_reg + 8'd1;
                        end
                    end

                    PH_CHAR_HDR:
                    begin
                        if (hdr_cnt_reg == 8'd0) begin
                            hold_next = {16'd0, item.data_byte};
                        end else if (hdr_cnt_reg == 8'd1) begin
                            dim_word = {item.data_byte, hold_reg[7:0]};
                            if (dim_word > MAX_DIM_W) begin
                                hold_next = hold_reg | 24'h010000;
                            end else begin
                                cur_width_next = dim_word[12:0];
                            end
                        end else if (hdr_cnt_reg == 8'd2) begin
                            hold_next = {hold_reg[23:16], item.data_byte, hold_reg[7:0]};
                        end else if (hdr_cnt_reg == 8'd3) begin
                            dim_word = {item.data_byte, hold_reg[15:8]};
                            if (dim_word > MAX_DIM_W) begin
                                hold_next = hold_reg | 24'h020000;
                            end else begin
                                cur_height_next = dim_word[12:0];
                            end
                        end

                        if (hdr_cnt_reg == CHAR_HDR_LAST) begin
                            hdr_cnt_next = '0;
                            res_valid    = 1'b1;
                            if (hold_reg[17:16] != 2'b00) begin
                                res.kind       = KIND_ERROR;
                                res.char_index = cur_char_reg;
                                res.error_code = ERR_TOO_BIG;
                                phase_next     = PH_ERROR;
                            end else begin
                                hold_next          = '0;
                                res.kind           = KIND_CHAR_HDR;
                                res.char_index     = cur_char_reg;
                                res.width          = cur_width_reg;
                                res.height         = cur_height_reg;
                                pixels_left_next   = area[24:0];
                                pixel_pos_next     = '0;
                                byte_in_pixel_next = '0;
                                if (cur_width_reg == 13'd0 || cur_height_reg == 13'd0) begin
                                    cur_char_next = next_char_idx;
                                    phase_next    = (next_char_idx == char_total_reg) ?
                                                    PH_DONE : PH_CHAR_HDR;
                                end else begin
                                    phase_next = PH_PIXELS;
                                end
                            end
                        end else begin
                            hdr_cnt_next = hdr_cnt_reg + 8'd1;
                        end
                    end

                    PH_PIXELS:
                    begin
                        if (rgba_reg && byte_in_pixel_reg != 2'd3) begin
                            case (byte_in_pixel_reg)
                                2'd0:    hold_next = {hold_reg[23:8], item.data_byte};
                                2'd1:    hold_next = {hold_reg[23:16], item.data_byte,
                                                      hold_reg[7:0]};
                                default: hold_next = {item.data_byte, hold_reg[15:0]};
                            endcase
                            byte_in_pixel_next = byte_in_pixel_reg + 2'd1;
                        end else begin
                            res_valid       = 1'b1;
                            res.kind        = KIND_PIXEL;
                            res.char_index  = cur_char_reg;
                            res.pixel_index = pixel_pos_reg;
                            res.alpha       = item.data_byte;
                            if (rgba_reg) begin
                                res.red            = hold_reg[7:0];
                                res.green          = hold_reg[15:8];
                                res.blue           = hold_reg[23:16];
                                byte_in_pixel_next = '0;
                                hold_next          = '0;
                            end else begin
                                res.red   = WHITE;
                                res.green = WHITE;
                                res.blue  = WHITE;
                            end
                            pixel_pos_next   = pixel_pos_reg + 24'd1;
                            pixels_left_next = left_dec;
                            if (left_dec == 25'd0) begin
                                cur_char_next = next_char_idx;
                                hdr_cnt_next  = '0;
                                hold_next     = '0;
                                phase_next    = (next_char_idx == char_total_reg) ?
                                                PH_DONE : PH_CHAR_HDR;
                            end
                        end
                    end

                    PH_DONE, PH_ERROR:
                    begin
                        // Bytes after the last character or after an error are dropped.
                    end

                    default:
                    begin
                        phase_next = PH_ERROR;
                    end
                endcase
            end
        end
    end

    // Two-entry output buffer: the skid register catches a result produced while
    // the output register is held by a downstream stall.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        skid_valid_next = skid_valid_reg;
        skid_next       = skid_reg;

        if (skid_valid_reg) begin
            if (out_pop || !out_valid_reg) begin
                out_valid_next  = 1'b1;
                out_next        = skid_reg;
                skid_valid_next = 1'b0;
            end
        end else if (!out_valid_reg || out_pop) begin
            out_valid_next = res_valid;
            out_next       = res;
        end else if (res_valid) begin
            skid_valid_next = 1'b1;
            skid_next       = res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg         <= PH_FONT_HDR;
            hdr_cnt_reg       <= '0;
            sig_ok_reg        <= 1'b1;
            rgba_reg          <= 1'b0;
            char_total_reg    <= '0;
            cur_char_reg      <= '0;
            cur_width_reg     <= '0;
            cur_height_reg    <= '0;
            pixels_left_reg   <= '0;
            pixel_pos_reg     <= '0;
            byte_in_pixel_reg <= '0;
            hold_reg          <= '0;
            out_valid_reg     <= 1'b0;
            skid_valid_reg    <= 1'b0;
        end else begin
            phase_reg         <= phase_next;
            hdr_cnt_reg       <= hdr_cnt_next;
            sig_ok_reg        <= sig_ok_next;
            rgba_reg          <= rgba_next;
            char_total_reg    <= char_total_next;
            cur_char_reg      <= cur_char_next;
            cur_width_reg     <= cur_width_next;
            cur_height_reg    <= cur_height_next;
            pixels_left_reg   <= pixels_left_next;
            pixel_pos_reg     <= pixel_pos_next;
            byte_in_pixel_reg <= byte_in_pixel_next;
            hold_reg          <= hold_next;
            out_valid_reg     <= out_valid_next;
            skid_valid_reg    <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    `ASSERT_SAME_CYCLE(a_skid_behind_out, clk, rst_n,
        skid_valid_reg, out_valid_reg,
        "skid register full while output register is empty")
    `ASSERT_SAME_CYCLE(a_pixels_pending, clk, rst_n,
        phase_reg == PH_PIXELS, pixels_left_reg != 25'd0,
        "pixel phase with no pixels left")
    `ASSERT_SAME_CYCLE(a_alpha_only_bytes, clk, rst_n,
        !rgba_reg, byte_in_pixel_reg == 2'd0,
        "byte count inside a pixel moved for a one-byte pixel format")
    `ASSERT_SAME_CYCLE(a_color_byte_silent, clk, rst_n,
        accept && item.command == CMD_BYTE && phase_reg == PH_PIXELS &&
        rgba_reg && byte_in_pixel_reg != 2'd3,
        !res_valid,
        "color byte of a pixel produced a result")
    `ASSERT_NEXT_CYCLE(a_error_sticks, clk, rst_n,
        phase_reg == PH_ERROR && !(accept && item.command == CMD_END),
        phase_reg == PH_ERROR,
        "left the error phase without an end command")

endmodule

// ===== verif/ffsp_tb_pkg.sv =====
// Font parser scoreboard: tracks the parser state and checks each result item.
package ffsp_tb_pkg;
    import ffsp_pkg::*;

    // The four signature bytes, first byte in the top bits.
    localparam logic [31:0] RFN_SIGNATURE = {8'h2E, 8'h72, 8'h66, 8'h6E};

    class font_item_scoreboard;
        typedef enum {AT_FONT_HDR, AT_CHAR_HDR, AT_PIXELS, AT_DONE, AT_FAILED} stage_t;

        stage_t      stage;
        logic [7:0]  hdr_count;
        bit          sig_ok;
        bit          rgba;
        logic [15:0] char_total;
        logic [15:0] cur_char;
        logic [12:0] cur_w;
        logic [12:0] cur_h;
        logic [24:0] pixels_left;
        logic [23:0] pix_pos;
        logic [1:0]  byte_in_pix;
        logic [23:0] hold;

        result_t     awaited_outputs[$];
        int unsigned mismatches;

        function new();
            mismatches = 0;
            restart();
        endfunction

        function void restart();
            stage       = AT_FONT_HDR;
            hdr_count   = '0;
            sig_ok      = 1'b1;
            rgba        = 1'b0;
            char_total  = '0;
            cur_char    = '0;
            cur_w       = '0;
            cur_h       = '0;
            pixels_left = '0;
            pix_pos     = '0;
            byte_in_pix = '0;
            hold        = '0;
        endfunction

        function void raise_error(err_t code);
            result_t r;
            r            = '0;
            r.kind       = KIND_ERROR;
            r.char_index = cur_char;
            r.error_code = code;
            awaited_outputs.push_back(r);
            stage = AT_FAILED;
        endfunction

        function void next_glyph();
            cur_char  = cur_char + 16'd1;
            hdr_count = '0;
            hold      = '0;
            stage     = (cur_char == char_total) ? AT_DONE : AT_CHAR_HDR;
        endfunction

        // Advances the parser state by one accepted item and queues what it produces.
        function void note_item(item_t it);
            logic [7:0]  b;
            logic [7:0]  c;
            logic [15:0] dim;
            logic [15:0] ver;
            result_t     r;
            b = it.data_byte;
            c = hdr_count;
            r = '0;
            if (it.command == CMD_END)
            begin
                if (stage == AT_DONE)
                begin
                    r.kind = KIND_DONE;
                    awaited_outputs.push_back(r);
                end
                else if (stage != AT_FAILED)
                begin
                    raise_error(ERR_TRUNCATED);
                end
                restart();
                return;
            end
            case (stage)
                AT_FONT_HDR:
                begin
                    if (c < 8'd4)
                    begin
                        if (b != RFN_SIGNATURE[31 - 8 * c -: 8])
                            sig_ok = 1'b0;
                    end
                    else if (c == 8'd4) hold = {16'h0, b};
                    else if (c == 8'd5) hold = {8'h0, b, hold[7:0]};
                    else if (c == 8'd6) char_total = {8'h0, b};
                    else if (c == 8'd7) char_total = {b, char_total[7:0]};
                    if (c == FONT_HDR_LAST)
                    begin
                        ver       = hold[15:0];
                        hdr_count = '0;
                        hold      = '0;
                        if (!sig_ok)
                            raise_error(ERR_SIGNATURE);
                        else if (ver != VERSION_ALPHA && ver != VERSION_RGBA)
                            raise_error(ERR_VERSION);
                        else if (char_total == 16'd0)
                            raise_error(ERR_NO_CHARS);
                        else
                        begin
                            rgba     = (ver == VERSION_RGBA);
                            cur_char = '0;
                            stage    = AT_CHAR_HDR;
                        end
                    end
                    else
                    begin
                        hdr_count = c + 8'd1;
                    end
                end
                AT_CHAR_HDR:
                begin
                    if (c == 8'd0)
                    begin
                        hold = {16'h0, b};
                    end
                    else if (c == 8'd1)
                    begin
                        dim = {b, hold[7:0]};
                        if (dim > MAX_DIM_DEFAULT) hold[16] = 1'b1;
                        else cur_w = dim[12:0];
                    end
                    else if (c == 8'd2)
                    begin
                        hold[15:8] = b;
                    end
                    else if (c == 8'd3)
                    begin
                        dim = {b, hold[15:8]};
                        if (dim > MAX_DIM_DEFAULT) hold[17] = 1'b1;
                        else cur_h = dim[12:0];
                    end
                    if (c == CHAR_HDR_LAST)
                    begin
                        hdr_count = '0;
                        if (hold[17:16] != 2'b00)
                        begin
                            raise_error(ERR_TOO_BIG);
                        end
                        else
                        begin
                            hold         = '0;
                            r.kind       = KIND_CHAR_HDR;
                            r.char_index = cur_char;
                            r.width      = cur_w;
                            r.height     = cur_h;
                            awaited_outputs.push_back(r);
                            pixels_left = 25'(cur_w) * 25'(cur_h);
                            pix_pos     = '0;
                            byte_in_pix = '0;
                            if (pixels_left == 25'd0) next_glyph();
                            else stage = AT_PIXELS;
                        end
                    end
                    else
                    begin
                        hdr_count = c + 8'd1;
                    end
                end
                AT_PIXELS:
                begin
                    // Version 2 collects red, green and blue before the alpha byte.
                    if (rgba && byte_in_pix != 2'd3)
                    begin
                        hold[8 * byte_in_pix +: 8] = b;
                        byte_in_pix = byte_in_pix + 2'd1;
                    end
                    else
                    begin
                        r.kind        = KIND_PIXEL;
                        r.char_index  = cur_char;
                        r.pixel_index = pix_pos;
                        r.alpha       = b;
                        if (rgba)
                        begin
                            r.red       = hold[7:0];
                            r.green     = hold[15:8];
                            r.blue      = hold[23:16];
                            byte_in_pix = '0;
                            hold        = '0;
                        end
                        else
                        begin
                            r.red   = WHITE;
                            r.green = WHITE;
                            r.blue  = WHITE;
                        end
                        awaited_outputs.push_back(r);
                        pix_pos     = pix_pos + 24'd1;
                        pixels_left = pixels_left - 25'd1;
                        if (pixels_left == 25'd0) next_glyph();
                    end
                end
                default: ;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s: expected %0d, actual %0d", name, want, got);
                mismatches++;
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited_outputs.size() == 0)
            begin
                $error("result item with none outstanding: kind %0d", got.kind);
                mismatches++;
                return;
            end
            want = awaited_outputs.pop_front();
            compare_field("kind", want.kind, got.kind);
            compare_field("char_index", want.char_index, got.char_index);
            compare_field("width", want.width, got.width);
            compare_field("height", want.height, got.height);
            compare_field("pixel_index", want.pixel_index, got.pixel_index);
            compare_field("red", want.red, got.red);
            compare_field("green", want.green, got.green);
            compare_field("blue", want.blue, got.blue);
            compare_field("alpha", want.alpha, got.alpha);
            compare_field("error_code", want.error_code, got.error_code);
        endfunction

        function bit all_arrived();
            return awaited_outputs.size() == 0;
        endfunction
    endclass

endpackage

// ===== verif/tb.sv =====
// Top-level testbench of the font file stream parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ffsp_pkg::*;
    import ffsp_tb_pkg::*;

    // Watchdog limit in cycles; far above the length of any legal run.
    localparam int unsigned CYCLE_LIMIT       = 500000;
    // Long receiver hold-off, well beyond the two result slots inside the block.
    localparam int unsigned HOLDOFF_CYCLES    = 120;
    // Counted items after which the second idling phase hands over to the third.
    localparam int unsigned SECOND_PHASE_END  = 1350;
    // Counted items the whole run aims for.
    localparam int unsigned ITEM_GOAL         = 1650;
    // Cycles allowed after the last expected result for stray items to show up.
    localparam int unsigned SETTLE_CYCLES     = 16;

    logic    clk;
    logic    rst_n;
    logic    item_valid;
    logic    item_stall;
    item_t   item;
    logic    result_valid;
    logic    result_stall;
    result_t result;

    // Idle rates of the two sides, in percent of cycles.
    int unsigned send_idle_pct;
    int unsigned recv_stall_pct;
    // Set once by the stimulus; the receiver then holds off for a long stretch.
    bit          holdoff_wanted;
    // Items counted towards the run goals; junk bytes sent on purpose are left out.
    int unsigned counted_items;
    // Truncation of the current file: bytes left before the end command replaces
    // the next byte (negative when the file runs to its end), and whether it happened.
    int          cut_budget;
    bit          file_cut;
    int unsigned cycles;

    font_item_scoreboard sb = new();

    font_file_stream_parser i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Both handshakes are sampled at the rising edge. Inputs only move at the falling
    // edge, and a result is registered after its item is taken, so the input
    // is noted before the result of the same edge is checked.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (item_valid && !item_stall)
                sb.note_item(item);
            if (result_valid && !result_stall)
                sb.check_result(result);
        end
    end

    // Receiver: random stalls at the current rate, plus one long hold-off when the
    // stimulus asks for it. The hold-off is counted here, independent of the sender.
    initial
    begin : result_receiver
        int unsigned holdoff_left;
        bit          holdoff_done;
        holdoff_left = 0;
        holdoff_done = 1'b0;
        result_stall = 1'b0;
        forever
        begin
            @(negedge clk);
            if (holdoff_wanted && !holdoff_done)
            begin
                holdoff_done = 1'b1;
                holdoff_left = HOLDOFF_CYCLES;
            end
            if (holdoff_left > 0)
            begin
                result_stall <= 1'b1;
                holdoff_left--;
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offers one item, with random idle cycles in front, and returns at the falling
    // edge after it was taken. Valid is only lowered when an idle cycle follows.
    task automatic send_item(input cmd_t cmd, input logic [7:0] data, input bit counts);
        while ($urandom_range(99) < send_idle_pct)
        begin
            item_valid <= 1'b0;
            @(negedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{command: cmd, data_byte: data};
        do
            @(posedge clk);
        while (item_stall);
        @(negedge clk);
        if (counts)
            counted_items++;
    endtask

    task automatic begin_file(input int cut);
        cut_budget = cut;
        file_cut   = 1'b0;
    endtask

    // One byte of the current file. When the truncation point is reached, the end
    // command goes out instead, and the rest of the file is dropped.
    task automatic put_byte(input logic [7:0] b);
        if (file_cut)
            return;
        if (cut_budget == 0)
        begin
            send_item(CMD_END, 8'($urandom), 1'b1);
            file_cut = 1'b1;
            return;
        end
        if (cut_budget > 0)
            cut_budget--;
        send_item(CMD_BYTE, b, 1'b1);
    endtask

    task automatic put_word(input logic [15:0] w);
        put_byte(w[7:0]);
        put_byte(w[15:8]);
    endtask

    task automatic end_file();
        if (!file_cut)
            send_item(CMD_END, 8'($urandom), 1'b1);
    endtask

    // Bytes sent after an error or after the last character; the parser drops them.
    task automatic put_junk(input int n);
        repeat (n)
        begin
            if (!file_cut)
                send_item(CMD_BYTE, 8'($urandom), 1'b0);
        end
    endtask

    // Font header: signature, version, character count and random reserved bytes.
    task automatic put_font_header(input logic [31:0] sig, input logic [15:0] ver,
                                   input logic [15:0] count);
        for (int i = 0; i < 4; i++)
            put_byte(sig[31 - 8 * i -: 8]);
        put_word(ver);
        put_word(count);
        repeat (248)
            put_byte(8'($urandom));
    endtask

    task automatic put_char_header(input logic [15:0] w, input logic [15:0] h);
        put_word(w);
        put_word(h);
        repeat (28)
            put_byte(8'($urandom));
    endtask

    task automatic put_pixels(input int n, input bit rgba);
        repeat (rgba ? 4 * n : n)
            put_byte(8'($urandom));
    endtask

    // Character sizes: mostly a handful of pixels, sometimes a zero-size character
    // whose other side may reach the limit, sometimes a wide strip.
    function automatic void pick_dims(output logic [15:0] w, output logic [15:0] h);
        case ($urandom_range(9))
            0:
            begin
                w = 16'd0;
                h = 16'($urandom_range(MAX_DIM_DEFAULT));
            end
            1:
            begin
                w = 16'($urandom_range(MAX_DIM_DEFAULT));
                h = 16'd0;
            end
            2:
            begin
                w = 16'($urandom_range(40, 1));
                h = 16'($urandom_range(2, 1));
            end
            default:
            begin
                w = 16'($urandom_range(5, 1));
                h = 16'($urandom_range(5, 1));
            end
        endcase
    endfunction

    // One random file. Most are well formed with random content; the rest have a broken
    // font header, an oversized character, or are plain noise. A quarter of the files
    // other than noise are set to be cut short at a random byte.
    task automatic send_random_file();
        int unsigned pick;
        int unsigned nchars;
        int unsigned bad_at;
        bit          rgba;
        logic [15:0] w;
        logic [15:0] h;
        logic [15:0] ver;
        logic [31:0] sig;
        pick   = $urandom_range(9);
        rgba   = $urandom_range(1);
        nchars = $urandom_range(4, 1);
        ver    = rgba ? VERSION_RGBA : VERSION_ALPHA;
        sig    = RFN_SIGNATURE;
        if ($urandom_range(3) == 0)
            begin_file(int'($urandom_range(256 + 70 * nchars)));
        else
            begin_file(-1);
        if (pick <= 5)
        begin
            put_font_header(sig, ver, 16'(nchars));
            for (int i = 0; i < nchars; i++)
            begin
                pick_dims(w, h);
                put_char_header(w, h);
                put_pixels(int'(w) * int'(h), rgba);
            end
            if ($urandom_range(3) == 0)
                put_junk($urandom_range(8, 1));
            end_file();
        end
        else if (pick == 6)
        begin
            // One flaw in the font header, then bytes that must be ignored.
            case ($urandom_range(2))
                0: sig[8 * $urandom_range(3) +: 8] ^= 8'($urandom_range(255, 1));
                1:
                begin
                    ver = 16'($urandom);
                    if (ver == VERSION_ALPHA || ver == VERSION_RGBA)
                        ver = 16'd0;
                end
                default: nchars = 0;
            endcase
            put_font_header(sig, ver, 16'(nchars));
            put_junk($urandom_range(6));
            end_file();
        end
        else if (pick == 7)
        begin
            // A character with a side above the limit somewhere in the font.
            put_font_header(sig, ver, 16'(nchars));
            bad_at = $urandom_range(nchars - 1);
            for (int i = 0; i <= bad_at; i++)
            begin
                pick_dims(w, h);
                if (i == bad_at)
                begin
                    case ($urandom_range(2))
                        0: w = 16'($urandom_range(65535, MAX_DIM_DEFAULT + 1));
                        1: h = 16'($urandom_range(65535, MAX_DIM_DEFAULT + 1));
                        default:
                        begin
                            w = 16'($urandom_range(65535, MAX_DIM_DEFAULT + 1));
                            h = 16'($urandom_range(65535, MAX_DIM_DEFAULT + 1));
                        end
                    endcase
                    put_char_header(w, h);
                end
                else
                begin
                    put_char_header(w, h);
                    put_pixels(int'(w) * int'(h), rgba);
                end
            end
            put_junk($urandom_range(4));
            end_file();
        end
        else
        begin
            // Noise: random bytes with the odd end command in between.
            repeat ($urandom_range(300, 1))
            begin
                if ($urandom_range(29) == 0)
                    send_item(CMD_END, 8'($urandom), 1'b1);
                else
                    send_item(CMD_BYTE, 8'($urandom), 1'b1);
            end
            send_item(CMD_END, 8'($urandom), 1'b1);
        end
    endtask

    initial
    begin : stimulus
        item_valid     = 1'b0;
        item           = '0;
        holdoff_wanted = 1'b0;
        counted_items  = 0;
        cut_budget     = -1;
        file_cut       = 1'b0;
        send_idle_pct  = 15;
        recv_stall_pct = 67;
        rst_n          = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // The fixed files run with a mostly busy sender and a slow receiver.

        // An end command straight after reset counts as a truncated font header.
        send_item(CMD_END, 8'hFF, 1'b1);

        // Bad signature, bad version and zero count together: the signature wins.
        // The bytes after the error are dropped and the end gives no item.
        begin_file(-1);
        put_font_header({RFN_SIGNATURE[31:8], 8'h6F}, 16'd3, 16'd0);
        put_junk(3);
        end_file();

        // No characters at all.
        begin_file(-1);
        put_font_header(RFN_SIGNATURE, VERSION_ALPHA, 16'd0);
        put_junk(4);
        end_file();

        // Version 2 with the largest count: zero-size characters at the size limit,
        // pixels with all-zero and all-one bytes, then an end inside a pixel.
        begin_file(-1);
        put_font_header(RFN_SIGNATURE, VERSION_RGBA, 16'hFFFF);
        put_char_header(16'd4096, 16'd0);
        put_char_header(16'd0, 16'd4096);
        put_char_header(16'd2, 16'd2);
        repeat (4) put_byte(8'h00);
        repeat (4) put_byte(8'hFF);
        put_pixels(2, 1'b1);
        put_char_header(16'd1, 16'd1);
        put_byte(8'h12);
        put_byte(8'h34);
        end_file();

        // Second character one pixel wider than the limit.
        begin_file(-1);
        put_font_header(RFN_SIGNATURE, VERSION_ALPHA, 16'd3);
        put_char_header(16'd1, 16'd2);
        put_pixels(2, 1'b0);
        put_char_header(16'd4097, 16'd1);
        put_junk(2);
        end_file();

        // Random files with a slow sender and a mostly ready receiver ...
        send_idle_pct  = 67;
        recv_stall_pct = 15;
        do
            send_random_file();
        while (counted_items < SECOND_PHASE_END);

        // ... and finally with no idling on either side. It opens with a long
        // receiver hold-off during a run of pixels, so that both result slots fill
        // and the parser has to stall its input while bytes keep coming.
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        begin_file(-1);
        put_font_header(RFN_SIGNATURE, VERSION_ALPHA, 16'd1);
        put_char_header(16'd4, 16'd4);
        holdoff_wanted = 1'b1;
        put_pixels(16, 1'b0);
        end_file();
        while (counted_items < ITEM_GOAL)
            send_random_file();
        item_valid <= 1'b0;

        // Wait for the outstanding results, then a little longer for strays.
        while (!sb.all_arrived())
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.all_arrived())
            $display("font_file_stream_parser test passed");
        else
            $display("font_file_stream_parser test failed");
        $finish;
    end

    initial
    begin : watchdog
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $error("timeout after %0d cycles", cycles);
        $display("font_file_stream_parser test failed");
        $finish;
    end

endmodule
